### src/tdn_pkg.sv
// types, constants and shared width helpers for the texel decode and normalize core
`default_nettype none
package tdn_pkg;

	localparam logic [1:0] MODE_COLOR    = 2'd0;
	localparam logic [1:0] MODE_NORMAL   = 2'd1;
	localparam logic [1:0] MODE_MATERIAL = 2'd2;

	localparam logic [1:0] ADDR_TEXTURE_MODE = 2'd0;

	localparam int QBITS = 16;
	localparam int SW    = 18;
	localparam int UW    = 37;
	localparam int LAT   = 3 + QBITS + 1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} texel_t;

	typedef struct packed {
		logic signed [15:0] comp_x;
		logic signed [15:0] comp_y;
		logic signed [15:0] comp_z;
		logic               zero_length;
	} vec_t;

	function automatic int rem_width(input int frac);
		int w;
		w = 2 * frac + 19;
		if (w < 54) begin
			w = 54;
		end
		return w + 1;
	endfunction

endpackage
`default_nettype wire

### src/tdn_lane.sv
// one vector component: pipelined bit-per-stage search for the rounded normalized magnitude
`default_nettype none
module tdn_lane #(
	parameter int FRAC_BITS = 15
) (
	input  logic                                      clk,
	input  logic [tdn_pkg::QBITS-1:0]                 ld,
	input  logic signed [tdn_pkg::rem_width(FRAC_BITS)-1:0] rem_in,
	input  logic signed [tdn_pkg::UW-1:0]             u_in,
	input  logic [tdn_pkg::SW-1:0]                    s_in,
	input  logic                                      neg_in,
	output logic [tdn_pkg::QBITS-1:0]                 mag,
	output logic                                      neg
);

	localparam int RW = tdn_pkg::rem_width(FRAC_BITS);
	localparam int QB = tdn_pkg::QBITS;
	localparam int UW = tdn_pkg::UW;
	localparam int SW = tdn_pkg::SW;

	// rem = target - (2q-1)^2 * s, u = (2q-1) * s
	logic signed [RW-1:0] rem_s [QB];
	logic signed [UW-1:0] u_s   [QB];
	logic [SW-1:0]        s_s   [QB];
	logic [QB-1:0]        q_s   [QB];
	logic [QB-1:0]        neg_s;

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;
		logic signed [RW-1:0] rem_p;
		logic signed [RW-1:0] dec_u;
		logic signed [RW-1:0] dec_s;
		logic signed [RW-1:0] rem_n;
		logic signed [UW-1:0] u_p;
		logic [SW-1:0]        s_p;
		logic [QB-1:0]        q_p;
		logic                 neg_p;
		logic                 take;

		if (j == 0) begin : g_first
			assign rem_p = rem_in;
			assign u_p   = u_in;
			assign s_p   = s_in;
			assign q_p   = '0;
			assign neg_p = neg_in;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign u_p   = u_s[j-1];
			assign s_p   = s_s[j-1];
			assign q_p   = q_s[j-1];
			assign neg_p = neg_s[j-1];
		end

		assign dec_u = {{(RW-UW){u_p[UW-1]}}, u_p} << (K + 2);
		assign dec_s = {{(RW-SW){1'b0}}, s_p} << (2 * K + 2);
		assign rem_n = rem_p - dec_u - dec_s;
		assign take  = !rem_n[RW-1];

		always_ff @(posedge clk) begin
			if (ld[j]) begin
				rem_s[j] <= take ? rem_n : rem_p;
				u_s[j]   <= take ? (u_p + ({{(UW-SW){1'b0}}, s_p} << (K + 1))) : u_p;
				s_s[j]   <= s_p;
				q_s[j]   <= q_p | ({{(QB-1){1'b0}}, take} << K);
				neg_s[j] <= neg_p;
			end
		end
	end

	assign mag = q_s[QB-1];
	assign neg = neg_s[QB-1];

endmodule
`default_nettype wire

### src/texel_decode_normalize_core.sv
// top level of the texel decode and normalize core
`default_nettype none
// Takes one RGB texel per cycle and returns one three-component vector per texel, in order.
// Color mode passes the channels through, normal mode normalizes (2c-255), material mode
// normalizes c; components are Q1.15 (FRAC_BITS fraction bits), rounded to nearest with ties
// away from zero and saturated to 16 bits. From accept to result a texel passes through
// the texel stage, square, sum, 16 root search stages with one result bit each and the output
// register, and a new texel is taken every cycle; a stalled output only holds back the stages
// behind it once they are full. Any APB write sets texture_mode, as paddr is not decoded.
module texel_decode_normalize_core #(
	parameter int FRAC_BITS = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            texel_valid,
	output logic            texel_stall,
	input  tdn_pkg::texel_t texel,
	output logic            vec_valid,
	input  logic            vec_stall,
	output tdn_pkg::vec_t   vec,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [1:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int RW  = tdn_pkg::rem_width(FRAC_BITS);
	localparam int QB  = tdn_pkg::QBITS;
	localparam int SW  = tdn_pkg::SW;
	localparam int UW  = tdn_pkg::UW;
	localparam int NST = tdn_pkg::LAT;

	typedef struct packed {
		logic [1:0]      mode;
		logic            zero;
		tdn_pkg::texel_t raw;
	} side_t;

	function automatic logic [8:0] decode_ch(input logic [7:0] c, input logic normal);
		logic [8:0] twice;
		twice = {c, 1'b0};
		if (!normal) begin
			return {1'b0, c};
		end
		if (c[7]) begin
			return {1'b0, 8'(twice - 9'd255)};
		end
		return {1'b1, 8'(9'd255 - twice)};
	endfunction

	function automatic logic signed [15:0] sat_comp(input logic n, input logic [QB-1:0] m);
		logic signed [15:0] r;
		if (n) begin
			r = m[15] ? 16'sh8000 : 16'(-m);
		end else begin
			r = m[15] ? 16'sh7fff : 16'(m);
		end
		return r;
	endfunction

	logic [1:0]     mode_q;
	logic [NST-1:0] vld_q;
	logic [NST-1:0] ld;

	// config port
	assign pready = 1'b1;
	assign prdata = {30'b0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tdn_pkg::MODE_COLOR;
		end else if (psel && penable && pwrite && pready) begin
			mode_q <= pwdata[1:0];
		end
	end

	// flow control, bubbles collapse toward the output
	assign ld[NST-1] = !vld_q[NST-1] || !vec_stall;
	for (genvar i = 0; i < NST - 1; i++) begin : g_ld
		assign ld[i] = !vld_q[i] || ld[i+1];
	end
	assign texel_stall = !ld[0];
	assign vec_valid   = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= texel_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: channel decode to magnitude and sign
	logic [8:0] dec_r, dec_g, dec_b;
	side_t      side_s1;
	logic [7:0] av_s1 [3];
	logic [2:0] neg_s1;

	assign dec_r = decode_ch(texel.red,   mode_q == tdn_pkg::MODE_NORMAL);
	assign dec_g = decode_ch(texel.green, mode_q == tdn_pkg::MODE_NORMAL);
	assign dec_b = decode_ch(texel.blue,  mode_q == tdn_pkg::MODE_NORMAL);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			side_s1.mode <= mode_q;
			side_s1.zero <= 1'b0;
			side_s1.raw  <= texel;
			av_s1[0]     <= dec_r[7:0];
			av_s1[1]     <= dec_g[7:0];
			av_s1[2]     <= dec_b[7:0];
			neg_s1       <= {dec_b[8], dec_g[8], dec_r[8]};
		end
	end

	// stage 2: squares
	side_t       side_s2;
	logic [15:0] sq_s2 [3];
	logic [2:0]  neg_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			side_s2 <= side_s1;
			neg_s2  <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= av_s1[i] * av_s1[i];
			end
		end
	end

	// stage 3: squared length and search start values
	logic [SW-1:0]        s_sum;
	side_t                side_s3;
	logic [SW-1:0]        s_s3;
	logic signed [UW-1:0] u_s3;
	logic signed [RW-1:0] rem_s3 [3];
	logic [2:0]           neg_s3;

	assign s_sum = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			side_s3.mode <= side_s2.mode;
			side_s3.raw  <= side_s2.raw;
			side_s3.zero <= (s_sum == '0) && (side_s2.mode == tdn_pkg::MODE_MATERIAL);
			s_s3         <= s_sum;
			u_s3         <= -{{(UW-SW){1'b0}}, s_sum};
			neg_s3       <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				rem_s3[i] <= {{(RW-2*FRAC_BITS-18){1'b0}}, sq_s2[i], {(2*FRAC_BITS+2){1'b0}}}
					- {{(RW-SW){1'b0}}, s_sum};
			end
		end
	end

	// root search lanes
	logic [QB-1:0] mag_l [3];
	logic [2:0]    neg_l;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		tdn_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.ld    (ld[3 +: QB]),
			.rem_in(rem_s3[c]),
			.u_in  (u_s3),
			.s_in  (s_s3),
			.neg_in(neg_s3[c]),
			.mag   (mag_l[c]),
			.neg   (neg_l[c])
		);
	end

	side_t side_ln [QB];

	for (genvar j = 0; j < QB; j++) begin : g_side
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ld[3]) begin
					side_ln[0] <= side_s3;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (ld[3+j]) begin
					side_ln[j] <= side_ln[j-1];
				end
			end
		end
	end

	// output stage
	side_t         side_o;
	tdn_pkg::vec_t vec_n;
	tdn_pkg::vec_t vec_s20;

	assign side_o = side_ln[QB-1];

	always_comb begin
		vec_n = '0;
		case (side_o.mode) inside
			tdn_pkg::MODE_COLOR: begin
				vec_n.comp_x = {8'b0, side_o.raw.red};
				vec_n.comp_y = {8'b0, side_o.raw.green};
				vec_n.comp_z = {8'b0, side_o.raw.blue};
			end
			tdn_pkg::MODE_NORMAL, tdn_pkg::MODE_MATERIAL: begin
				if (side_o.zero) begin
					vec_n.zero_length = 1'b1;
				end else begin
					vec_n.comp_x = sat_comp(neg_l[0], mag_l[0]);
					vec_n.comp_y = sat_comp(neg_l[1], mag_l[1]);
					vec_n.comp_z = sat_comp(neg_l[2], mag_l[2]);
				end
			end
			default: begin
				vec_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[NST-1]) begin
			vec_s20 <= vec_n;
		end
	end

	assign vec = vec_s20;

endmodule
`default_nettype wire

### src/tdn_checker.sv
// port-level checks for the texel decode and normalize core, bound to the top level
`default_nettype none
module tdn_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            texel_valid,
	input logic            texel_stall,
	input tdn_pkg::texel_t texel,
	input logic            vec_valid,
	input logic            vec_stall,
	input tdn_pkg::vec_t   vec,
	input logic            psel,
	input logic            penable,
	input logic            pwrite,
	input logic [1:0]      paddr,
	input logic [31:0]     pwdata,
	input logic [31:0]     prdata,
	input logic            pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vec_valid && vec_stall |=> vec_valid && $stable(vec))
		else $error("stalled result changed");

	// input only backs up when the output is full and stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!vec_valid || !vec_stall) |-> !texel_stall)
		else $error("input stalled with a free output");

	// after each accepted item, vec_valid is high once the pipeline latency LAT has passed
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && !texel_stall |-> ##(tdn_pkg::LAT) vec_valid)
		else $error("no result after pipeline latency");

	// zero-length flag forces zero components
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vec_valid && vec.zero_length |->
			vec.comp_x == 16'sd0 && vec.comp_y == 16'sd0 && vec.comp_z == 16'sd0)
		else $error("zero-length result with nonzero components");

endmodule

bind texel_decode_normalize_core tdn_checker u_tdn_checker (.*);
`default_nettype wire

### verif/tdn_checker.sv
// checker for the texel decode core: tracks the mode, predicts each vector and compares results
module tdn_scoreboard #(
	parameter int FRAC_BITS = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            texel_valid,
	input  logic            texel_stall,
	input  tdn_pkg::texel_t texel,
	input  logic            vec_valid,
	input  logic            vec_stall,
	input  tdn_pkg::vec_t   vec,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [1:0]      paddr,
	input  logic [31:0]     pwdata,
	input  logic            pready,
	output int              mismatch_count,
	output int              vecs_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0] texture_mode_q;
	tdn_pkg::vec_t predicted_vecs [$];

	// largest q with (2q-1)^2 * sumsq <= 4 * av^2 * 2^(2F): rounds half away from zero
	function automatic longint unsigned scaled_root_mag(longint unsigned av,
			longint unsigned sumsq);
		longint unsigned target;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned odd;
		target = (4 * av * av) << (2 * FRAC_BITS);
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 2 * mid - 1;
			if (odd * odd * sumsq <= target) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	function automatic logic signed [15:0] clamp_component(bit neg, longint unsigned mag);
		longint unsigned wrapped;
		if (neg) begin
			if (mag > 32768) begin
				mag = 32768;
			end
			wrapped = 64'd0 - mag;
		end else begin
			if (mag > 32767) begin
				mag = 32767;
			end
			wrapped = mag;
		end
		return wrapped[15:0];
	endfunction

	function automatic tdn_pkg::vec_t decode_texel(logic [1:0] mode, tdn_pkg::texel_t t);
		tdn_pkg::vec_t r;
		logic [7:0] ch [3];
		longint v [3];
		logic signed [15:0] c [3];
		longint unsigned sumsq;
		r = '0;
		ch[0] = t.red;
		ch[1] = t.green;
		ch[2] = t.blue;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = '0;
		end
		case (mode) inside
		tdn_pkg::MODE_COLOR: begin
			for (int i = 0; i < 3; i++) begin
				c[i] = {8'd0, ch[i]};
			end
		end
		tdn_pkg::MODE_NORMAL, tdn_pkg::MODE_MATERIAL: begin
			for (int i = 0; i < 3; i++) begin
				if (mode == tdn_pkg::MODE_NORMAL) begin
					v[i] = 2 * longint'(ch[i]) - 255;
				end else begin
					v[i] = longint'(ch[i]);
				end
				sumsq += v[i] * v[i];
			end
			if (sumsq == 0) begin
				r.zero_length = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					c[i] = clamp_component(v[i] < 0,
						scaled_root_mag((v[i] < 0) ? -v[i] : v[i], sumsq));
				end
			end
		end
		default: ;
		endcase
		r.comp_x = c[0];
		r.comp_y = c[1];
		r.comp_z = c[2];
		return r;
	endfunction

	function automatic int field_differs(string fname, logic signed [15:0] want,
			logic signed [15:0] got);
		if (want === got) begin
			return 0;
		end
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tdn_pkg::vec_t want;
		int bad;
		if (!arst_n) begin
			texture_mode_q <= tdn_pkg::MODE_COLOR;
			predicted_vecs.delete();
			mismatch_count <= 0;
			vecs_in_flight <= 0;
		end else begin
			bad = 0;
			if (vec_valid && !vec_stall) begin
				if (predicted_vecs.size() == 0) begin
					$display("%0t: vector mismatch, expected none, actual %h", $time, vec);
					bad++;
				end else begin
					want = predicted_vecs.pop_front();
					bad += field_differs("comp_x", want.comp_x, vec.comp_x);
					bad += field_differs("comp_y", want.comp_y, vec.comp_y);
					bad += field_differs("comp_z", want.comp_z, vec.comp_z);
					bad += field_differs("zero_length", {15'd0, want.zero_length},
						{15'd0, vec.zero_length});
				end
			end
			if (texel_valid && !texel_stall) begin
				predicted_vecs.push_back(decode_texel(texture_mode_q, texel));
			end
			if (psel && penable && pwrite && pready
					&& paddr == tdn_pkg::ADDR_TEXTURE_MODE) begin
				texture_mode_q <= pwdata[1:0];
			end
			mismatch_count <= mismatch_count + bad;
			vecs_in_flight <= predicted_vecs.size();
		end
	end

endmodule

### verif/tb_top.sv
// testbench top for the texel decode core: drives texels, mode writes and output stalls
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int RANDOM_PHASES    = 8;
	localparam int TEXELS_PER_PHASE = 232;
	localparam int GAP_PCT          = 22;
	localparam int CYCLE_LIMIT      = 200000;

	localparam tdn_pkg::texel_t CORNERS [6] = '{24'h000000, 24'hffffff, 24'hff8080,
		24'h007f80, 24'h8000ff, 24'h000001};
	localparam logic [1:0] PHASE_MODES [4] = '{tdn_pkg::MODE_COLOR, tdn_pkg::MODE_NORMAL,
		tdn_pkg::MODE_MATERIAL, MODE_RESERVED};

	logic            clk;
	logic            arst_n;
	logic            texel_valid;
	logic            texel_stall;
	tdn_pkg::texel_t texel;
	logic            vec_valid;
	logic            vec_stall = 1'b0;
	tdn_pkg::vec_t   vec;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [1:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;
	int              mismatch_count;
	int              vecs_in_flight;
	int              cycle_count;
	bit              gaps_on = 1'b1;

	texel_decode_normalize_core #(.FRAC_BITS(15)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.texel_valid(texel_valid),
		.texel_stall(texel_stall),
		.texel      (texel),
		.vec_valid  (vec_valid),
		.vec_stall  (vec_stall),
		.vec        (vec),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	tdn_scoreboard #(.FRAC_BITS(15)) u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.texel_valid   (texel_valid),
		.texel_stall   (texel_stall),
		.texel         (texel),
		.vec_valid     (vec_valid),
		.vec_stall     (vec_stall),
		.vec           (vec),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatch_count(mismatch_count),
		.vecs_in_flight(vecs_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		vec_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
	end

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
		0: return 8'd0;
		1: return 8'd255;
		2: return 8'($urandom_range(127, 128));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_texture_mode(input logic [1:0] mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tdn_pkg::ADDR_TEXTURE_MODE;
		pwdata <= {30'd0, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_texel(input tdn_pkg::texel_t t);
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			texel_valid <= 1'b0;
			@(posedge clk);
		end
		texel_valid <= 1'b1;
		texel <= t;
		@(posedge clk);
		while (texel_stall) @(posedge clk);
	endtask

	// let every vector in flight come out before touching the mode
	task automatic drain();
		texel_valid <= 1'b0;
		@(posedge clk);
		while (vecs_in_flight != 0) @(posedge clk);
		repeat (tdn_pkg::LAT + 4) @(posedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[texel_decode_normalize_core] ERROR");
		$finish;
	end

	initial begin
		logic [1:0] mode;
		tdn_pkg::texel_t t;
		arst_n <= 1'b0;
		texel_valid <= 1'b0;
		texel <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= tdn_pkg::ADDR_TEXTURE_MODE;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner texels in every mode, the first set on the reset mode
		foreach (PHASE_MODES[m]) begin
			if (m != 0) begin
				write_texture_mode(PHASE_MODES[m]);
			end
			foreach (CORNERS[k]) begin
				push_texel(CORNERS[k]);
			end
			drain();
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 4) begin
				mode = PHASE_MODES[(p + 2) % 4];
			end else begin
				mode = 2'($urandom_range(0, 3));
			end
			gaps_on = (p != 5);
			write_texture_mode(mode);
			for (int n = 0; n < TEXELS_PER_PHASE; n++) begin
				if ($urandom_range(0, 31) == 0) begin
					t = '0;
				end else begin
					t.red = pick_channel();
					t.green = pick_channel();
					t.blue = pick_channel();
				end
				push_texel(t);
			end
			drain();
		end

		if (mismatch_count == 0 && vecs_in_flight == 0) begin
			$display("[texel_decode_normalize_core] OK");
		end else begin
			$display("[texel_decode_normalize_core] ERROR");
		end
		$finish;
	end

endmodule
